FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file gdau_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define GDAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gdau port property violated");

// clocked property that is also checked during reset
`define GDAU_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("gdau reset property violated");

`endif

FILE: rtl/gdau_pkg.sv
// ----------------------------------------------------------------------------
// gdau_pkg
// Types, constants and constant-divisor helpers of the date arithmetic unit.
// ----------------------------------------------------------------------------
package gdau_pkg;

    // opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_DIFF  = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd3;

    // pipeline depth, accept to result register
    localparam int PIPE_DEPTH = 13;

    // day numbers count from march 1st of year -400
    localparam logic [16:0] YEAR_SHIFT = 17'd400;
    localparam logic [17:0] ERA_DAYS   = 18'd146097;
    localparam int          DEC31_DOY  = 305;
    localparam logic [24:0] Z_FIRST    = 25'd146037;
    localparam logic [21:0] DIST_MAX   = 22'h3fffff;

    // reciprocals, each exact over the operand range it is used on
    localparam logic [17:0] R_Y100   = 18'd167773;
    localparam logic [17:0] R_Y400   = 18'd167773;
    localparam logic [25:0] R_ERA    = 26'd60207212;
    localparam logic [18:0] R_D1460  = 19'd367720;
    localparam logic [18:0] R_D36524 = 19'd470373;
    localparam logic [18:0] R_D365   = 19'd367720;
    localparam logic [9:0]  R_S100   = 10'd656;
    localparam logic [11:0] R_M153   = 12'd3427;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cnt;
        logic        inval;
        logic        ovf;
        logic [21:0] distance;
        logic [4:0]  da;
        logic [3:0]  ma;
        logic [13:0] ya;
        logic [7:0]  qa;
        logic [4:0]  db;
        logic [3:0]  mb;
        logic [13:0] yb;
        logic [7:0]  qb;
        logic [16:0] sya;
        logic [16:0] syb;
        logic [3:0]  mpa;
        logic [3:0]  mpb;
        logic [10:0] h100a;
        logic [10:0] h100b;
        logic [8:0]  h400a;
        logic [8:0]  h400b;
        logic [8:0]  doya;
        logic [8:0]  doyb;
        logic [24:0] za;
        logic [24:0] zb;
        logic [24:0] z;
        logic [7:0]  era;
        logic [17:0] doe;
        logic [7:0]  q1460;
        logic [2:0]  q36524;
        logic        era_end;
        logic [17:0] t;
        logic [8:0]  yoe;
        logic [6:0]  yq4;
        logic [2:0]  yq100;
        logic [16:0] yy;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [4:0]  rday;
        logic [3:0]  rmon;
        logic [13:0] ryear;
    } pipe_t;

    function automatic logic [10:0] div100_y(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(R_Y100);
        return p[34:24];
    endfunction

    function automatic logic [8:0] div400_y(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(R_Y400);
        return p[34:26];
    endfunction

    function automatic logic [7:0] div_era(input logic [24:0] x);
        logic [50:0] p;
        p = 51'(x) * 51'(R_ERA);
        return p[50:43];
    endfunction

    function automatic logic [7:0] div1460(input logic [17:0] x);
        logic [36:0] p;
        p = 37'(x) * 37'(R_D1460);
        return p[36:29];
    endfunction

    function automatic logic [2:0] div36524(input logic [17:0] x);
        logic [36:0] p;
        p = 37'(x) * 37'(R_D36524);
        return p[36:34];
    endfunction

    function automatic logic [8:0] div365(input logic [17:0] x);
        logic [36:0] p;
        p = 37'(x) * 37'(R_D365);
        return p[35:27];
    endfunction

    function automatic logic [2:0] div100_s(input logic [8:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'(R_S100);
        return p[18:16];
    endfunction

    function automatic logic [3:0] div153(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(R_M153);
        return p[22:19];
    endfunction

    // first day of a march-based month within its year
    function automatic logic [8:0] mar_doy(input logic [3:0] mp);
        logic [8:0] v;
        unique case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/gregorian_date_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit_core
// Gregorian date add, subtract, difference and check on stream channels.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the opcode, s_tdata the
// two dates and the day count. Results leave on the m_ channel: m_tdata
// carries the result date and the day distance, m_tuser the invalid and
// overflow flags. Dates are turned into day numbers, moved by the count and
// turned back, all by constant reciprocal multiplies.
// One request may enter every cycle while no stage is held by a stall, set by
// the 13 stage pipeline with at most a few parallel constant multiplies and a
// short add chain per stage.
// Reset clears all stage valid bits; the pipeline is empty afterwards.
// When the receiver stalls, each full stage holds while the one after it cannot
// move on; empty stages keep filling, and s_tready drops once the first stage
// cannot move on.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit_core #(
    parameter int MAX_DAY_COUNT = 65535,
    parameter int MAX_YEAR      = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // day_a[4:0] month_a[8:5] year_a[22:9] day_b[27:23] month_b[31:28]
    // year_b[45:32] day_count[61:46], zero pad above
    input  logic [63:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_day[4:0] result_month[8:5] result_year[22:9]
    // day_distance[44:23], zero pad above
    output logic [47:0] m_tdata,
    // invalid_date[0] year_overflow[1]
    output logic [1:0]  m_tuser
);

    localparam int          NS       = gdau_pkg::PIPE_DEPTH;
    localparam int          YEAR_TOP = MAX_YEAR + 400;
    localparam logic [24:0] Z_MAX    = 25'(YEAR_TOP * 365 + YEAR_TOP / 4 - YEAR_TOP / 100
                                           + YEAR_TOP / 400 + gdau_pkg::DEC31_DOY);

    gdau_pkg::pipe_t st_reg  [NS];
    gdau_pkg::pipe_t st_next [NS];
    logic [NS-1:0]   v_reg;
    logic [NS-1:0]   v_next;
    logic [NS-1:0]   en;

    logic [13:0] ra;
    logic [13:0] rb;
    logic        leap_a;
    logic        leap_b;
    logic        bad_a;
    logic        bad_b;
    logic [25:0] sum;
    logic [25:0] lim;
    logic [24:0] diff;
    logic [3:0]  mon;
    logic        keep;

    // stage enables, from the output back
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    // valid bits travel with the data
    always_comb begin
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NS; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    // stage logic
    always_comb begin
        // unpack request, shift years, clamp count
        st_next[0]     = '0;
        st_next[0].op  = s_tuser;
        st_next[0].da  = s_tdata[4:0];
        st_next[0].ma  = s_tdata[8:5];
        st_next[0].ya  = s_tdata[22:9];
        st_next[0].db  = s_tdata[27:23];
        st_next[0].mb  = s_tdata[31:28];
        st_next[0].yb  = s_tdata[45:32];
        st_next[0].cnt = ({4'd0, s_tdata[61:46]} > 20'(MAX_DAY_COUNT)) ?
                         16'(MAX_DAY_COUNT) : s_tdata[61:46];
        st_next[0].qa  = 8'(gdau_pkg::div100_y(17'(s_tdata[22:9])));
        st_next[0].qb  = 8'(gdau_pkg::div100_y(17'(s_tdata[45:32])));
        st_next[0].sya = 17'(s_tdata[22:9]) + gdau_pkg::YEAR_SHIFT
                         - 17'(s_tdata[8:5] <= 4'd2);
        st_next[0].syb = 17'(s_tdata[45:32]) + gdau_pkg::YEAR_SHIFT
                         - 17'(s_tdata[31:28] <= 4'd2);
        st_next[0].mpa = (s_tdata[8:5] > 4'd2) ? s_tdata[8:5] - 4'd3 : s_tdata[8:5] + 4'd9;
        st_next[0].mpb = (s_tdata[31:28] > 4'd2) ? s_tdata[31:28] - 4'd3
                                                 : s_tdata[31:28] + 4'd9;

        // date validity, year divisions, month offset
        st_next[1] = st_reg[0];
        ra     = st_reg[0].ya - 14'(st_reg[0].qa) * 14'd100;
        rb     = st_reg[0].yb - 14'(st_reg[0].qb) * 14'd100;
        leap_a = (st_reg[0].ya[1:0] == 2'd0) && (ra != 14'd0 || st_reg[0].qa[1:0] == 2'd0);
        leap_b = (st_reg[0].yb[1:0] == 2'd0) && (rb != 14'd0 || st_reg[0].qb[1:0] == 2'd0);
        bad_a  = st_reg[0].ma < 4'd1 || st_reg[0].ma > 4'd12 || st_reg[0].da < 5'd1
                 || 17'(st_reg[0].ya) > 17'(MAX_YEAR)
                 || st_reg[0].da > gdau_pkg::month_len(st_reg[0].ma, leap_a);
        bad_b  = st_reg[0].mb < 4'd1 || st_reg[0].mb > 4'd12 || st_reg[0].db < 5'd1
                 || 17'(st_reg[0].yb) > 17'(MAX_YEAR)
                 || st_reg[0].db > gdau_pkg::month_len(st_reg[0].mb, leap_b);
        st_next[1].inval = bad_a || (st_reg[0].op == gdau_pkg::OP_DIFF && bad_b);
        st_next[1].h100a = gdau_pkg::div100_y(st_reg[0].sya);
        st_next[1].h100b = gdau_pkg::div100_y(st_reg[0].syb);
        st_next[1].h400a = gdau_pkg::div400_y(st_reg[0].sya);
        st_next[1].h400b = gdau_pkg::div400_y(st_reg[0].syb);
        st_next[1].doya  = gdau_pkg::mar_doy(st_reg[0].mpa);
        st_next[1].doyb  = gdau_pkg::mar_doy(st_reg[0].mpb);

        // day numbers
        st_next[2]    = st_reg[1];
        st_next[2].za = 25'(st_reg[1].sya) * 25'd365 + 25'(st_reg[1].sya[16:2])
                        - 25'(st_reg[1].h100a) + 25'(st_reg[1].h400a)
                        + 25'(st_reg[1].doya) + 25'(st_reg[1].da) - 25'd1;
        st_next[2].zb = 25'(st_reg[1].syb) * 25'd365 + 25'(st_reg[1].syb[16:2])
                        - 25'(st_reg[1].h100b) + 25'(st_reg[1].h400b)
                        + 25'(st_reg[1].doyb) + 25'(st_reg[1].db) - 25'd1;

        // move by the count, saturate at the year range, distance
        st_next[3] = st_reg[2];
        sum  = 26'(st_reg[2].za) + 26'(st_reg[2].cnt);
        lim  = 26'(gdau_pkg::Z_FIRST) + 26'(st_reg[2].cnt);
        diff = (st_reg[2].za >= st_reg[2].zb) ? st_reg[2].za - st_reg[2].zb
                                              : st_reg[2].zb - st_reg[2].za;
        st_next[3].distance = (diff > 25'(gdau_pkg::DIST_MAX)) ? gdau_pkg::DIST_MAX
                                                               : diff[21:0];
        unique case (st_reg[2].op)
            gdau_pkg::OP_ADD: begin
                st_next[3].ovf = sum > 26'(Z_MAX);
                st_next[3].z   = (sum > 26'(Z_MAX)) ? Z_MAX : sum[24:0];
            end
            gdau_pkg::OP_SUB: begin
                st_next[3].ovf = 26'(st_reg[2].za) < lim;
                st_next[3].z   = (26'(st_reg[2].za) < lim) ? gdau_pkg::Z_FIRST
                                 : st_reg[2].za - 25'(st_reg[2].cnt);
            end
            default: begin
                st_next[3].ovf = 1'b0;
                st_next[3].z   = gdau_pkg::Z_FIRST;
            end
        endcase

        // 400 year era
        st_next[4]     = st_reg[3];
        st_next[4].era = gdau_pkg::div_era(st_reg[3].z);

        // day of era
        st_next[5]     = st_reg[4];
        st_next[5].doe = 18'(st_reg[4].z - 25'(st_reg[4].era) * 25'(gdau_pkg::ERA_DAYS));

        // leap corrections within the era
        st_next[6]         = st_reg[5];
        st_next[6].q1460   = gdau_pkg::div1460(st_reg[5].doe);
        st_next[6].q36524  = gdau_pkg::div36524(st_reg[5].doe);
        st_next[6].era_end = st_reg[5].doe == gdau_pkg::ERA_DAYS - 18'd1;

        st_next[7]   = st_reg[6];
        st_next[7].t = st_reg[6].doe - 18'(st_reg[6].q1460) + 18'(st_reg[6].q36524)
                       - 18'(st_reg[6].era_end);

        // year of era
        st_next[8]     = st_reg[7];
        st_next[8].yoe = gdau_pkg::div365(st_reg[7].t);

        st_next[9]       = st_reg[8];
        st_next[9].yq4   = st_reg[8].yoe[8:2];
        st_next[9].yq100 = gdau_pkg::div100_s(st_reg[8].yoe);
        st_next[9].yy    = 17'(st_reg[8].era) * 17'd400 + 17'(st_reg[8].yoe);

        // day of year
        st_next[10]     = st_reg[9];
        st_next[10].doy = 9'(st_reg[9].doe - (18'(st_reg[9].yoe) * 18'd365
                          + 18'(st_reg[9].yq4) - 18'(st_reg[9].yq100)));

        // march-based month
        st_next[11]    = st_reg[10];
        st_next[11].mp = gdau_pkg::div153(11'(st_reg[10].doy) * 11'd5 + 11'd2);

        // calendar date and result masking
        st_next[12] = st_reg[11];
        mon  = (st_reg[11].mp < 4'd10) ? st_reg[11].mp + 4'd3 : st_reg[11].mp - 4'd9;
        keep = !st_reg[11].inval
               && (st_reg[11].op == gdau_pkg::OP_ADD || st_reg[11].op == gdau_pkg::OP_SUB);
        st_next[12].rday  = keep ? 5'(st_reg[11].doy - gdau_pkg::mar_doy(st_reg[11].mp)
                                      + 9'd1) : 5'd0;
        st_next[12].rmon  = keep ? mon : 4'd0;
        st_next[12].ryear = keep ? 14'(st_reg[11].yy - gdau_pkg::YEAR_SHIFT
                                       + 17'(mon <= 4'd2)) : 14'd0;
        st_next[12].ovf   = keep && st_reg[11].ovf;
        st_next[12].distance = (!st_reg[11].inval && st_reg[11].op == gdau_pkg::OP_DIFF) ?
                               st_reg[11].distance : 22'd0;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {3'd0, st_reg[NS-1].distance, st_reg[NS-1].ryear,
                       st_reg[NS-1].rmon, st_reg[NS-1].rday};
    assign m_tuser  = {st_reg[NS-1].ovf, st_reg[NS-1].inval};

endmodule

FILE: rtl/gdau_checker.sv
// ----------------------------------------------------------------------------
// gdau_checker
// Port-level properties of the date arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdau_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // no result right after reset
    `GDAU_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid)

    // a stalled result holds
    `GDAU_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an invalid date zeroes every other field
    `GDAU_ASSERT(a_invalid_zero, m_tvalid && m_tuser[0] |-> m_tdata == 48'd0 && !m_tuser[1])

    // a date result is a real month and day and carries no distance
    `GDAU_ASSERT(a_date_shape, m_tvalid && m_tdata[8:5] != 4'd0 |-> m_tdata[8:5] <= 4'd12 && m_tdata[4:0] != 5'd0 && m_tdata[44:23] == 22'd0)

    // overflow saturates to the last or the first day of the range
    `GDAU_ASSERT(a_ovf_sat, m_tvalid && m_tuser[1] |-> (m_tdata[4:0] == 5'd31 && m_tdata[8:5] == 4'd12) || (m_tdata[4:0] == 5'd1 && m_tdata[8:5] == 4'd1 && m_tdata[22:9] == 14'd0))

endmodule

bind gregorian_date_arithmetic_unit_core gdau_checker u_gdau_checker (.*);
